// File: hw/rtl/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;
    localparam int CELLS     = COLUMNS * ROWS;

    // Internal widths
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int COLT_W = $clog2(COLUMNS + TAB_WIDTH);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ROWT_W = ROW_W + 1;
    localparam int PH_W   = $clog2(TAB_WIDTH);

    // Port field widths
    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int OCOL_W = 7;
    localparam int OROW_W = 5;
    localparam int OFF_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    // Scan limits over the cell store
    localparam logic [ADDR_W-1:0] LAST_CELL      = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY      = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] FIRST_LAST_ROW = ADDR_W'(CELLS - COLUMNS);

    // Reset values
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] CELL_RESET = 16'h0F20;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Cursor; phase tracks col modulo the tab width
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PH_W-1:0]  phase;
    } t_cursor;

    // Outcome of one put-character step
    typedef struct packed {
        t_cursor cur;
        logic    print;
        logic    scroll;
    } t_step;

endpackage

// File: hw/rtl/tccw_if.sv
`timescale 1ns / 1ps

// Request channel
interface tccw_req_if
    import tccw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, output req_type, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input req_type, input char_code, input cell_index,
                    output ready);
endinterface

// Result channel
interface tccw_res_if
    import tccw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OCOL_W-1:0] cursor_col;
    logic [OROW_W-1:0] cursor_row;
    logic [OFF_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_data;

    modport source (output valid, output cursor_col, output cursor_row,
                    output cursor_offset, output cell_data, input ready);
    modport sink   (input valid, input cursor_col, input cursor_row,
                    input cursor_offset, input cell_data, output ready);
endinterface

// File: hw/rtl/tccw_cursor.sv
`timescale 1ns / 1ps

// Cursor update for one put-character beat
module tccw_cursor
    import tccw_pkg::*;
(
    input  t_cursor           i_cur,
    input  logic [CHAR_W-1:0] i_char,
    output t_step             o_step
);

    logic [COLT_W-1:0] col_t;
    logic [ROWT_W-1:0] row_t;
    logic [PH_W-1:0]   ph;
    logic              print;
    logic              scroll;

    always_comb begin
        col_t = COLT_W'(i_cur.col);
        row_t = ROWT_W'(i_cur.row);
        ph    = i_cur.phase;
        print = 1'b0;

        // character handling
        if (i_char == CH_BS) begin
            if (i_cur.col != '0) begin
                col_t = col_t - 1'b1;
                ph    = (ph == '0) ? PH_W'(TAB_WIDTH - 1) : ph - 1'b1;
            end
        end else if (i_char == CH_TAB) begin
            col_t = col_t + COLT_W'(TAB_WIDTH) - COLT_W'(ph);
            ph    = '0;
        end else if (i_char == CH_CR) begin
            col_t = '0;
            ph    = '0;
        end else if (i_char == CH_LF) begin
            col_t = '0;
            ph    = '0;
            row_t = row_t + 1'b1;
        end else if (i_char >= CH_SPACE) begin
            print = 1'b1;
            col_t = col_t + 1'b1;
            ph    = (ph == PH_W'(TAB_WIDTH - 1)) ? '0 : ph + 1'b1;
        end

        // line wrap
        if (col_t >= COLT_W'(COLUMNS)) begin
            col_t = '0;
            ph    = '0;
            row_t = row_t + 1'b1;
        end

        // past the bottom row: scroll and stay on the last row
        scroll = (row_t >= ROWT_W'(ROWS));
        if (scroll) begin
            row_t = ROWT_W'(ROWS - 1);
        end

        o_step.cur.col   = COL_W'(col_t);
        o_step.cur.row   = ROW_W'(row_t);
        o_step.cur.phase = ph;
        o_step.print     = print;
        o_step.scroll    = scroll;
    end

endmodule

// File: hw/rtl/text_console_cell_writer.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    req_type, char_code, cell_index
// o_res     out  valid/ready    cursor_col, cursor_row, cursor_offset, cell_data
// i_cfg_*   in   write enable   text_attribute (8 bits)
//
// Plain puts, ignored codes and control codes go straight to ST_EMIT; reads pass ST_READ first.
// A scroll copies the cell RAM up one row (one copy per cycle), then blanks the last row;
// a clear blanks all CELLS entries. The cell RAM has one write port and one
// registered read port.
// After reset a clearing pass writes 0x0F20 to every cell;
// no request is taken meanwhile, configuration writes are.
// A result waits in the output register; the next request is taken meanwhile.
module text_console_cell_writer
    import tccw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    tccw_req_if.sink          i_req,
    tccw_res_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata
);

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_READ   = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_BLANK  = 6'b010000,
        ST_EMIT   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_cursor           r_cur, n_cur;
    logic [ATTR_W-1:0] r_attr;
    logic [ADDR_W-1:0] r_scan, n_scan;
    logic              r_we, n_we;
    logic [ADDR_W-1:0] r_wa, n_wa;
    logic              r_wsel, n_wsel;
    logic [CELL_W-1:0] r_wd, n_wd;
    logic [CELL_W-1:0] r_rdata;
    logic              r_rd_ok, n_rd_ok;
    logic [CELL_W-1:0] r_res_data, n_res_data;
    logic              r_out_valid;
    logic [OCOL_W-1:0] r_out_col;
    logic [OROW_W-1:0] r_out_row;
    logic [OFF_W-1:0]  r_out_off;
    logic [CELL_W-1:0] r_out_data;

    logic [CELL_W-1:0] mem [CELLS];

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              req_ready;
    logic              out_load;
    logic [ADDR_W-1:0] cur_lin;
    logic [CELL_W-1:0] blank;
    t_step             step;

    // put-character cursor logic
    tccw_cursor u_cursor (
        .i_cur  (r_cur),
        .i_char (i_req.char_code),
        .o_step (step)
    );

    assign cur_lin = ADDR_W'(r_cur.row) * ADDR_W'(COLUMNS) + ADDR_W'(r_cur.col);
    assign blank   = {r_attr, CH_SPACE};

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_scan     = r_scan;
        n_we       = 1'b0;
        n_wa       = r_wa;
        n_wsel     = 1'b0;
        n_wd       = r_wd;
        n_rd_ok    = r_rd_ok;
        n_res_data = r_res_data;
        rd_en      = 1'b0;
        rd_addr    = '0;
        req_ready  = 1'b0;
        out_load   = 1'b0;

        case (r_state)
            ST_INIT: begin
                n_we = 1'b1;
                n_wa = r_scan;
                n_wd = CELL_RESET;
                if (r_scan == LAST_CELL) begin
                    n_scan  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            ST_IDLE: begin
                // hold off while a write is still on its way to the RAM
                req_ready = !r_we;
                if (i_req.valid && req_ready) begin
                    n_res_data = '0;
                    case (i_req.req_type)
                        REQ_PUT: begin
                            n_cur  = step.cur;
                            n_scan = '0;
                            if (step.print) begin
                                n_we = 1'b1;
                                n_wa = cur_lin;
                                n_wd = {r_attr, i_req.char_code};
                            end
                            n_state = step.scroll ? ST_SCROLL : ST_EMIT;
                        end
                        REQ_CLEAR: begin
                            n_cur   = '0;
                            n_scan  = '0;
                            n_state = ST_BLANK;
                        end
                        REQ_READ: begin
                            rd_en   = 1'b1;
                            rd_addr = ADDR_W'(i_req.cell_index);
                            n_rd_ok = (32'(i_req.cell_index) < CELLS);
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_res_data = r_rd_ok ? r_rdata : '0;
                n_state    = ST_EMIT;
            end
            ST_SCROLL: begin
                // read one row down, write it back here next cycle
                rd_en   = 1'b1;
                rd_addr = r_scan + ADDR_W'(COLUMNS);
                n_we    = 1'b1;
                n_wa    = r_scan;
                n_wsel  = 1'b1;
                if (r_scan == LAST_COPY) begin
                    n_scan  = FIRST_LAST_ROW;
                    n_state = ST_BLANK;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            ST_BLANK: begin
                n_we = 1'b1;
                n_wa = r_scan;
                n_wd = blank;
                if (r_scan == LAST_CELL) begin
                    n_state = ST_EMIT;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cur   <= '0;
            r_scan  <= '0;
            r_we    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_scan  <= n_scan;
            r_we    <= n_we;
        end
    end

    // attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_wa       <= n_wa;
        r_wsel     <= n_wsel;
        r_wd       <= n_wd;
        r_rd_ok    <= n_rd_ok;
        r_res_data <= n_res_data;
    end

    // cell RAM: one registered read, one write from the write registers
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (r_we) begin
            mem[r_wa] <= r_wsel ? r_rdata : r_wd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_col  <= OCOL_W'(r_cur.col);
            r_out_row  <= OROW_W'(r_cur.row);
            r_out_off  <= OFF_W'(cur_lin);
            r_out_data <= r_res_data;
        end
    end

    assign i_req.ready         = req_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.cursor_col    = r_out_col;
    assign o_res.cursor_row    = r_out_row;
    assign o_res.cursor_offset = r_out_off;
    assign o_res.cell_data     = r_out_data;

endmodule
